[hdl/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and codes for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   localparam int FUNC_W  = 2;
   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   localparam logic [SIZE_W-1:0] ROWS_RST = SIZE_W'(25);
   localparam logic [SIZE_W-1:0] COLS_RST = SIZE_W'(25);

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

   // boundary modes
   localparam logic [MODE_W-1:0] MODE_CLASSIC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DOUGHNUT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIRROR   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd2;

endpackage

[hdl/life_grid_generation_step.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Game of Life grid (B3/S23) held in RAM: cell write, cell read and a full
// generation advance with classic, doughnut or mirror edges.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  req      in   req_valid/req_stall func, row, col, value
//  rsp      out  rsp_valid/rsp_stall cell_res, out_of_range, done_res
//  csr      in   csr_wr_en           csr_index, csr_wr_data
//
//  Write, no-op and out-of-range read: answered from S_IDLE. In-range read:
//  one RAM read (S_RD). Advance: 9 reads of the cell RAM and a scratch write
//  per used cell (S_WALK, S_FIN), then a copy back per used cell (S_COPY).
//  After reset a clearing pass writes MAX_ROWS*MAX_COLS cells, one per cycle;
//  req_stall is high meanwhile. A stalled result blocks new transfers.
// ----------------------------------------------------------------------------
module life_grid_generation_step #(
   parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lgs_pkg::FUNC_W-1:0]    req_func,
   input  logic [lgs_pkg::COORD_W-1:0]   req_row,
   input  logic [lgs_pkg::COORD_W-1:0]   req_col,
   input  logic                          req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_cell_res,
   output logic                          rsp_out_of_range,
   output logic                          rsp_done_res,
   input  logic                          csr_wr_en,
   input  logic [lgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lgs_pkg::CSR_DAT_W-1:0] csr_wr_data
);
   import lgs_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int UR = $clog2(MAX_ROWS + 1);
   localparam int UC = $clog2(MAX_COLS + 1);
   localparam int UW0 = (UR > UC) ? UR : UC;
   localparam int UW = (UW0 > SIZE_W) ? UW0 : SIZE_W;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_RD, S_WALK, S_FIN, S_COPY, S_CPLAST
   } state_type;

   state_type         state_ff;
   logic [SIZE_W-1:0] rows_ff, cols_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [AW-1:0]     clr_ff;
   logic [RW-1:0]     r_ff;
   logic [CW-1:0]     c_ff;
   logic [1:0]        dri_ff, dci_ff;
   logic              vld_ff, skip_ff, center_ff;
   logic [3:0]        cnt_ff;
   logic              own_ff;
   logic              cp_vld_ff;
   logic [AW-1:0]     cp_addr_ff;
   logic              rsp_valid_ff, rsp_cell_ff, rsp_oor_ff, rsp_done_ff;

   function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
   endfunction

   // sizes in use
   logic [UW-1:0] used_rows, used_cols;
   logic [RW-1:0] last_row;
   logic [CW-1:0] last_col;

   always_comb begin
      if (rows_ff == '0) used_rows = UW'(1);
      else if (UW'(rows_ff) > UW'(MAX_ROWS)) used_rows = UW'(MAX_ROWS);
      else used_rows = UW'(rows_ff);
      if (cols_ff == '0) used_cols = UW'(1);
      else if (UW'(cols_ff) > UW'(MAX_COLS)) used_cols = UW'(MAX_COLS);
      else used_cols = UW'(cols_ff);
   end

   assign last_row = RW'(used_rows - UW'(1));
   assign last_col = CW'(used_cols - UW'(1));

   // request decode
   logic          accept, in_rng, rsp_now;
   logic [AW-1:0] req_addr;

   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign in_rng    = (UW'(req_row) < used_rows) && (UW'(req_col) < used_cols);
   assign req_addr  = cell_addr(RW'(UW'(req_row)), CW'(UW'(req_col)));
   // transfer answered right at the accepting edge
   assign rsp_now   = accept && (req_func != FUNC_ADVANCE)
                      && !((req_func == FUNC_READ) && in_rng);

   // neighbor coordinate for the current walk step
   logic [RW-1:0] nr;
   logic [CW-1:0] nc;
   logic          r_off, c_off;

   always_comb begin
      nr = r_ff;
      r_off = 1'b0;
      case (dri_ff)
         2'd0: begin
            if (r_ff == '0) begin
               r_off = 1'b1;
               nr = (mode_ff == MODE_DOUGHNUT) ? last_row : r_ff;
            end else begin
               nr = r_ff - RW'(1);
            end
         end
         2'd2: begin
            if (r_ff == last_row) begin
               r_off = 1'b1;
               nr = (mode_ff == MODE_DOUGHNUT) ? '0 : r_ff;
            end else begin
               nr = r_ff + RW'(1);
            end
         end
         default: nr = r_ff;
      endcase
      nc = c_ff;
      c_off = 1'b0;
      case (dci_ff)
         2'd0: begin
            if (c_ff == '0) begin
               c_off = 1'b1;
               nc = (mode_ff == MODE_DOUGHNUT) ? last_col : c_ff;
            end else begin
               nc = c_ff - CW'(1);
            end
         end
         2'd2: begin
            if (c_ff == last_col) begin
               c_off = 1'b1;
               nc = (mode_ff == MODE_DOUGHNUT) ? '0 : c_ff;
            end else begin
               nc = c_ff + CW'(1);
            end
         end
         default: nc = c_ff;
      endcase
   end

   // RAM hookup
   logic          cells_we, cells_wd, cells_rd;
   logic [AW-1:0] cells_wa, cells_ra;
   logic          next_we, next_wd, next_rd;
   logic [AW-1:0] next_wa, next_ra;
   logic [AW-1:0] cur_addr;
   logic [3:0]    total;
   logic          new_val;

   assign cur_addr = cell_addr(r_ff, c_ff);
   assign total = cnt_ff + ((vld_ff && !skip_ff && !center_ff) ? {3'b000, cells_rd} : 4'd0);

   always_comb begin
      if (mode_ff != MODE_CLASSIC && mode_ff != MODE_DOUGHNUT && mode_ff != MODE_MIRROR)
         new_val = 1'b0;
      else if (total == 4'd3) new_val = 1'b1;
      else if (total == 4'd2) new_val = own_ff;
      else new_val = 1'b0;
   end

   always_comb begin
      cells_we = 1'b0;
      cells_wa = cp_addr_ff;
      cells_wd = next_rd;
      if (state_ff == S_CLR) begin
         cells_we = 1'b1;
         cells_wa = clr_ff;
         cells_wd = 1'b0;
      end else if (state_ff == S_IDLE) begin
         cells_we = accept && (req_func == FUNC_WRITE) && in_rng;
         cells_wa = req_addr;
         cells_wd = req_value;
      end else if (state_ff == S_COPY || state_ff == S_CPLAST) begin
         cells_we = cp_vld_ff;
      end
      cells_ra = (state_ff == S_WALK) ? cell_addr(nr, nc) : req_addr;
      next_we  = (state_ff == S_FIN);
      next_wa  = cur_addr;
      next_wd  = new_val;
      next_ra  = cur_addr;
   end

   lgs_ram #(.WIDTH(1), .DEPTH(DEPTH), .AW(AW)) u_cells (
      .clock(clock), .wr_en(cells_we), .wr_addr(cells_wa), .wr_data(cells_wd),
      .rd_addr(cells_ra), .rd_data(cells_rd)
   );

   lgs_ram #(.WIDTH(1), .DEPTH(DEPTH), .AW(AW)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(next_ra), .rd_data(next_rd)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RST;
         cols_ff <= COLS_RST;
         mode_ff <= MODE_CLASSIC;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_wr_data;
            CSR_COLS: cols_ff <= csr_wr_data;
            CSR_MODE: mode_ff <= csr_wr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // control and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
         cp_vld_ff    <= 1'b0;
         r_ff         <= '0;
         c_ff         <= '0;
         dri_ff       <= '0;
         dci_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_now) rsp_valid_ff <= 1'b0;
         vld_ff <= (state_ff == S_WALK);
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  r_ff   <= '0;
                  c_ff   <= '0;
                  dri_ff <= '0;
                  dci_ff <= '0;
                  cnt_ff <= '0;
                  if ((req_func == FUNC_READ) && in_rng) begin
                     state_ff <= S_RD;
                  end else if (req_func == FUNC_ADVANCE) begin
                     state_ff <= S_WALK;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_cell_ff  <= 1'b0;
                     rsp_oor_ff   <= ((req_func == FUNC_WRITE) || (req_func == FUNC_READ))
                                     && !in_rng;
                     rsp_done_ff  <= (req_func == FUNC_WRITE) || (req_func == FUNC_READ);
                  end
               end
            end
            S_RD: begin
               rsp_valid_ff <= 1'b1;
               rsp_cell_ff  <= cells_rd;
               rsp_oor_ff   <= 1'b0;
               rsp_done_ff  <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_WALK: begin
               // collect the previous read, issue the next one
               if (vld_ff) begin
                  if (center_ff) own_ff <= cells_rd;
                  else if (!skip_ff) cnt_ff <= cnt_ff + {3'b000, cells_rd};
               end
               skip_ff   <= (r_off || c_off) && (mode_ff == MODE_CLASSIC);
               center_ff <= (dri_ff == 2'd1) && (dci_ff == 2'd1);
               if (dci_ff == 2'd2) begin
                  dci_ff <= '0;
                  if (dri_ff == 2'd2) begin
                     dri_ff   <= '0;
                     state_ff <= S_FIN;
                  end else begin
                     dri_ff <= dri_ff + 2'd1;
                  end
               end else begin
                  dci_ff <= dci_ff + 2'd1;
               end
            end
            S_FIN: begin
               cnt_ff <= '0;
               if (c_ff == last_col) begin
                  c_ff <= '0;
                  if (r_ff == last_row) begin
                     r_ff     <= '0;
                     state_ff <= S_COPY;
                  end else begin
                     r_ff     <= r_ff + RW'(1);
                     state_ff <= S_WALK;
                  end
               end else begin
                  c_ff     <= c_ff + CW'(1);
                  state_ff <= S_WALK;
               end
            end
            S_COPY: begin
               cp_vld_ff  <= 1'b1;
               cp_addr_ff <= cur_addr;
               if (c_ff == last_col) begin
                  c_ff <= '0;
                  if (r_ff == last_row) begin
                     r_ff     <= '0;
                     state_ff <= S_CPLAST;
                  end else begin
                     r_ff <= r_ff + RW'(1);
                  end
               end else begin
                  c_ff <= c_ff + CW'(1);
               end
            end
            S_CPLAST: begin
               cp_vld_ff    <= 1'b0;
               rsp_valid_ff <= 1'b1;
               rsp_cell_ff  <= 1'b0;
               rsp_oor_ff   <= 1'b0;
               rsp_done_ff  <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_res     = rsp_cell_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

[hdl/lgs_ram.sv]
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/life_grid_checker.sv]
// ----------------------------------------------------------------------------
// life_grid_checker
// Watches the req, rsp and csr ports of the life grid block. It keeps its own
// copy of the grid and the registers, predicts the result of every accepted
// request and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module life_grid_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [lgs_pkg::FUNC_W-1:0]    req_func,
   input  logic [lgs_pkg::COORD_W-1:0]   req_row,
   input  logic [lgs_pkg::COORD_W-1:0]   req_col,
   input  logic                          req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_cell_res,
   input  logic                          rsp_out_of_range,
   input  logic                          rsp_done_res,
   input  logic                          csr_wr_en,
   input  logic [lgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lgs_pkg::CSR_DAT_W-1:0] csr_wr_data,
   output int                            fail_count,
   output int                            results_due,
   output int                            results_seen
);
   import lgs_pkg::*;

   typedef struct packed {
      logic cell_bit;
      logic oor;
      logic done;
   } cell_result_type;

   logic [MAX_COLS_DEF-1:0] grid      [MAX_ROWS_DEF];
   logic [MAX_COLS_DEF-1:0] grid_next [MAX_ROWS_DEF];
   logic [SIZE_W-1:0]       rows_reg;
   logic [SIZE_W-1:0]       cols_reg;
   logic [MODE_W-1:0]       mode_reg;
   cell_result_type         result_q[$];

   function automatic int clamp_size(logic [SIZE_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   // live neighbours of (r, c); -1 for the unused edge mode
   function automatic int count_live(int r, int c, int nrows, int ncols);
      int n;
      int nr;
      int nc;
      n = 0;
      if (mode_reg > MODE_MIRROR) return -1;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            nr = r + dr;
            nc = c + dc;
            if (mode_reg == MODE_CLASSIC) begin
               if (nr < 0 || nr >= nrows || nc < 0 || nc >= ncols) continue;
            end else if (mode_reg == MODE_DOUGHNUT) begin
               if (nr < 0) nr = nrows - 1; else if (nr >= nrows) nr = 0;
               if (nc < 0) nc = ncols - 1; else if (nc >= ncols) nc = 0;
            end else begin
               // mirror: off-grid coordinate folds onto the cell itself
               if (nr < 0 || nr >= nrows) nr = r;
               if (nc < 0 || nc >= ncols) nc = c;
            end
            n += grid[nr][nc];
         end
      end
      return n;
   endfunction

   function automatic void step_generation();
      int nrows;
      int ncols;
      int n;
      nrows = clamp_size(rows_reg, MAX_ROWS_DEF);
      ncols = clamp_size(cols_reg, MAX_COLS_DEF);
      for (int r = 0; r < nrows; r++) begin
         for (int c = 0; c < ncols; c++) begin
            n = count_live(r, c, nrows, ncols);
            grid_next[r][c] = (n == 3) ? 1'b1 : (n == 2) ? grid[r][c] : 1'b0;
         end
      end
      for (int r = 0; r < nrows; r++)
         for (int c = 0; c < ncols; c++)
            grid[r][c] = grid_next[r][c];
   endfunction

   function automatic cell_result_type predict_cell_op(logic [FUNC_W-1:0] f,
      int r, int c, logic v);
      cell_result_type res;
      res = '0;
      if (f == FUNC_WRITE || f == FUNC_READ) begin
         res.done = 1'b1;
         if (r >= clamp_size(rows_reg, MAX_ROWS_DEF) ||
             c >= clamp_size(cols_reg, MAX_COLS_DEF)) begin
            res.oor = 1'b1;
         end else if (f == FUNC_WRITE) begin
            grid[r][c] = v;
         end else begin
            res.cell_bit = grid[r][c];
         end
      end else if (f == FUNC_ADVANCE) begin
         step_generation();
         res.done = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic got, logic want);
      $display("mismatch at result %0d: %s got %0b expected %0b",
               results_seen, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         for (int r = 0; r < MAX_ROWS_DEF; r++) grid[r] = '0;
         rows_reg = ROWS_RST;
         cols_reg = COLS_RST;
         mode_reg = MODE_CLASSIC;
         result_q.delete();
         fail_count   = 0;
         results_seen = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ROWS) rows_reg = csr_wr_data;
            else if (csr_index == CSR_COLS) cols_reg = csr_wr_data;
            else if (csr_index == CSR_MODE) mode_reg = csr_wr_data[MODE_W-1:0];
         end
         if (req_valid && !req_stall)
            result_q.push_back(predict_cell_op(req_func, int'(req_row),
                                               int'(req_col), req_value));
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $display("unexpected result transfer with nothing pending");
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_cell_res !== want.cell_bit)
                  report_mismatch("cell_res", rsp_cell_res, want.cell_bit);
               if (rsp_out_of_range !== want.oor)
                  report_mismatch("out_of_range", rsp_out_of_range, want.oor);
               if (rsp_done_res !== want.done)
                  report_mismatch("done_res", rsp_done_res, want.done);
            end
            results_seen++;
         end
      end
      results_due = result_q.size();
   end

endmodule

[tb/life_grid_generation_step_tb.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb
// Drives the life grid block through several sizes and edge modes: corner
// and out-of-range accesses, small patterns, then random write/read/advance
// traffic with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module life_grid_generation_step_tb;
   import lgs_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func;
   logic [COORD_W-1:0]   req_row;
   logic [COORD_W-1:0]   req_col;
   logic                 req_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_cell_res;
   logic                 rsp_out_of_range;
   logic                 rsp_done_res;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wr_data;

   int  fail_count;
   int  results_due;
   int  results_seen;
   int  items_sent;
   int  advances_sent;
   bit  send_calm;
   bit  take_calm;
   int  used_rows;
   int  used_cols;

   life_grid_generation_step i_dut (.*);

   life_grid_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("timeout waiting for results");
      $display("FAILED: results differ");
      $finish;
   end

   // result side: random stall per transfer, one long hold-off
   initial begin
      int wait_cycles;
      bit held;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (!held && results_seen >= 120) begin
               held = 1'b1;
               wait_cycles = 400;
            end else begin
               if ($urandom_range(0, 29) == 0) take_calm = ~take_calm;
               wait_cycles = take_calm ? 0 : $urandom_range(0, 14);
            end
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   function automatic int clamp_size(int v, int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DAT_W'(data);
      @(posedge clock);
   endtask

   task automatic set_grid(int nrows, int ncols, int mode);
      write_reg(CSR_ROWS, nrows);
      write_reg(CSR_COLS, ncols);
      write_reg(CSR_MODE, mode);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      used_rows = clamp_size(nrows, MAX_ROWS_DEF);
      used_cols = clamp_size(ncols, MAX_COLS_DEF);
   endtask

   task automatic send_op(logic [FUNC_W-1:0] f, int r, int c, logic v);
      int gap;
      if ($urandom_range(0, 19) == 0) send_calm = ~send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_row   <= COORD_W'(r);
      req_col   <= COORD_W'(c);
      req_value <= v;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (f == FUNC_ADVANCE) advances_sent++;
   endtask

   // pause until every result is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_coord(int used);
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, used - 1);
      return $urandom_range(0, 63);
   endfunction

   task automatic random_traffic(int count);
      int pick;
      int adv_odds;
      // advancing a big grid walks and copies every cell, so keep those rare
      adv_odds = (used_rows * used_cols > 256) ? 1 : 12;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < adv_odds)
            send_op(FUNC_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom));
         else if (pick < 55)
            send_op(FUNC_WRITE, pick_coord(used_rows), pick_coord(used_cols),
                    $urandom_range(0, 9) < 6);
         else if (pick < 94)
            send_op(FUNC_READ, pick_coord(used_rows), pick_coord(used_cols),
                    1'($urandom));
         else
            send_op(FUNC_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom));
      end
   endtask

   initial begin
      int phase_rows[9] = '{4, 1, 0, 64, 127, 8, 3, 6, 10};
      int phase_cols[9] = '{4, 1, 0, 64, 100, 5, 7, 6, 12};
      int phase_mode[9] = '{MODE_CLASSIC, MODE_DOUGHNUT, MODE_MIRROR, MODE_DOUGHNUT,
                            MODE_CLASSIC, MODE_MIRROR, MODE_UNUSED, MODE_DOUGHNUT,
                            MODE_CLASSIC};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_func    = FUNC_WRITE;
      req_row     = '0;
      req_col     = '0;
      req_value   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_ROWS;
      csr_wr_data = '0;
      items_sent    = 0;
      advances_sent = 0;
      send_calm = 1'b0;
      take_calm = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // clearing pass after reset
      while (req_stall) @(posedge clock);

      // reset size 25x25 classic: blinker and a cell past the edge
      used_rows = 25;
      used_cols = 25;
      send_op(FUNC_READ, 24, 24, 1'b0);
      send_op(FUNC_WRITE, 25, 0, 1'b1);
      send_op(FUNC_WRITE, 5, 4, 1'b1);
      send_op(FUNC_WRITE, 5, 5, 1'b1);
      send_op(FUNC_WRITE, 5, 6, 1'b1);
      send_op(FUNC_ADVANCE, 0, 0, 1'b0);
      send_op(FUNC_READ, 4, 5, 1'b0);
      send_op(FUNC_READ, 5, 4, 1'b0);
      send_op(FUNC_NOP, 63, 63, 1'b1);
      drain();

      // full size: field extremes, corners under doughnut wrap
      set_grid(64, 64, MODE_DOUGHNUT);
      send_op(FUNC_WRITE, 0, 0, 1'b1);
      send_op(FUNC_WRITE, 63, 63, 1'b1);
      send_op(FUNC_WRITE, 0, 63, 1'b1);
      send_op(FUNC_READ, 63, 63, 1'b0);
      send_op(FUNC_ADVANCE, 63, 63, 1'b1);
      send_op(FUNC_READ, 63, 0, 1'b0);
      send_op(FUNC_READ, 0, 0, 1'b0);
      drain();

      // small mirror grid: edge cell counts itself, out-of-range accesses
      set_grid(3, 3, MODE_MIRROR);
      send_op(FUNC_WRITE, 0, 0, 1'b1);
      send_op(FUNC_WRITE, 0, 1, 1'b1);
      send_op(FUNC_WRITE, 3, 1, 1'b1);
      send_op(FUNC_READ, 1, 3, 1'b0);
      send_op(FUNC_ADVANCE, 0, 0, 1'b0);
      send_op(FUNC_READ, 0, 0, 1'b0);
      send_op(FUNC_READ, 1, 1, 1'b0);
      drain();

      for (int p = 0; p < 9; p++) begin
         set_grid(phase_rows[p], phase_cols[p], phase_mode[p]);
         random_traffic(48);
         drain();
      end

      $display("sent %0d requests (%0d advances), checked %0d results",
               items_sent, advances_sent, results_seen);
      $display("covered sizes from 0 up to 127 and all four edge mode codes");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
